// ===== hw/rtl/lpfl_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfl_pkg: shared types and constants for the lifetime pool free list
// Default sizes, field widths, item kind codes and the cell control beat.
// ----------------------------------------------------------------------------
package lpfl_pkg;

  localparam int POOL_ENTRIES_DEF = 8;
  localparam int COORD_BITS_DEF   = 16;

  localparam int LIFE_W  = 8;
  localparam int FIELD_W = 16;
  localparam int SLOT_W  = 3;

  localparam logic KIND_CREATE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/lpfl_cell.sv =====
// ----------------------------------------------------------------------------
// lpfl_cell: one pool entry in the rotating chain
// Holds life, position, velocity and free-list link of one entry. On a shift
// it takes its neighbor's entry; on a load it takes a newly created entry.
// ----------------------------------------------------------------------------
module lpfl_cell #(
  parameter int COORD_BITS = lpfl_pkg::COORD_BITS_DEF,
  parameter int LINK_W     = 4,
  parameter int RESET_LINK = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lpfl_pkg::cell_ctrl_t       ctrl,
  input  logic [lpfl_pkg::LIFE_W-1:0] sh_life,
  input  logic [COORD_BITS-1:0]      sh_px,
  input  logic [COORD_BITS-1:0]      sh_py,
  input  logic [COORD_BITS-1:0]      sh_vx,
  input  logic [COORD_BITS-1:0]      sh_vy,
  input  logic [LINK_W-1:0]          sh_link,
  input  logic [lpfl_pkg::LIFE_W-1:0] ld_life,
  input  logic [COORD_BITS-1:0]      ld_px,
  input  logic [COORD_BITS-1:0]      ld_py,
  input  logic [COORD_BITS-1:0]      ld_vx,
  input  logic [COORD_BITS-1:0]      ld_vy,
  output logic [lpfl_pkg::LIFE_W-1:0] life,
  output logic [COORD_BITS-1:0]      px,
  output logic [COORD_BITS-1:0]      py,
  output logic [COORD_BITS-1:0]      vx,
  output logic [COORD_BITS-1:0]      vy,
  output logic [LINK_W-1:0]          link
);

  always_ff @(posedge clk) begin
    if (rst) begin
      life <= '0;
      link <= LINK_W'(RESET_LINK);
    end else if (ctrl.shift) begin
      life <= sh_life;
      link <= sh_link;
    end else if (ctrl.load) begin
      life <= ld_life;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      px <= sh_px;
      py <= sh_py;
      vx <= sh_vx;
      vy <= sh_vy;
    end else if (ctrl.load) begin
      px <= ld_px;
      py <= ld_py;
      vx <= ld_vx;
      vy <= ld_vy;
    end
  end

endmodule

// ===== hw/rtl/lifetime_pool_free_list.sv =====
// ----------------------------------------------------------------------------
// lifetime_pool_free_list: entry pool handed out from a linked free list
// A create beat pops the free-list head and loads that entry. A tick beat
// rotates the entry chain once, updating the entry at the chain head each
// cycle and pushing expired entries onto the free list.
//
//   channel   ports                                     handshake
//   input     kind lifetime start_x start_y vel_x vel_y start / busy
//   result    slot accepted live life_left pos_x pos_y  strobe
//             released last
//
// A create gives its result in the cycle after acceptance; busy stays low.
// A tick holds busy while it takes one chain step per entry, and
// gives one result per entry, in the cycle after each step.
// Reset clears all lives and rebuilds the free list in index order.
// Results are shown for one cycle on strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module lifetime_pool_free_list #(
  parameter int POOL_ENTRIES = lpfl_pkg::POOL_ENTRIES_DEF,
  parameter int COORD_BITS   = lpfl_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              kind,
  input  logic [lpfl_pkg::LIFE_W-1:0]       lifetime,
  input  logic signed [lpfl_pkg::FIELD_W-1:0] start_x,
  input  logic signed [lpfl_pkg::FIELD_W-1:0] start_y,
  input  logic signed [lpfl_pkg::FIELD_W-1:0] vel_x,
  input  logic signed [lpfl_pkg::FIELD_W-1:0] vel_y,
  output logic                              strobe,
  output logic [lpfl_pkg::SLOT_W-1:0]       slot,
  output logic                              accepted,
  output logic                              live,
  output logic [lpfl_pkg::LIFE_W-1:0]       life_left,
  output logic signed [lpfl_pkg::FIELD_W-1:0] pos_x,
  output logic signed [lpfl_pkg::FIELD_W-1:0] pos_y,
  output logic                              released,
  output logic                              last
);

  localparam int IDX_W  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int LINK_W = $clog2(POOL_ENTRIES + 1);
  localparam int LW     = lpfl_pkg::LIFE_W;

  logic [LW-1:0]         c_life [POOL_ENTRIES];
  logic [COORD_BITS-1:0] c_px   [POOL_ENTRIES];
  logic [COORD_BITS-1:0] c_py   [POOL_ENTRIES];
  logic [COORD_BITS-1:0] c_vx   [POOL_ENTRIES];
  logic [COORD_BITS-1:0] c_vy   [POOL_ENTRIES];
  logic [LINK_W-1:0]     c_link [POOL_ENTRIES];

  logic [LW-1:0]         s_life [POOL_ENTRIES];
  logic [COORD_BITS-1:0] s_px   [POOL_ENTRIES];
  logic [COORD_BITS-1:0] s_py   [POOL_ENTRIES];
  logic [COORD_BITS-1:0] s_vx   [POOL_ENTRIES];
  logic [COORD_BITS-1:0] s_vy   [POOL_ENTRIES];
  logic [LINK_W-1:0]     s_link [POOL_ENTRIES];

  logic              running;
  logic [IDX_W-1:0]  cnt;
  logic [LINK_W-1:0] free_head;

  logic              accept;
  logic              create_ok;
  logic [IDX_W-1:0]  head_idx;
  logic              cnt_last;

  logic signed [31:0]    sx_ext, sy_ext, vx_ext, vy_ext;
  logic [COORD_BITS-1:0] ld_px, ld_py, ld_vx, ld_vy;

  logic                  p_was_live;
  logic [LW-1:0]         p_life;
  logic                  p_live;
  logic                  p_rel;
  logic [COORD_BITS-1:0] p_px, p_py;
  logic [31:0]           o_px, o_py, n_px, n_py;

  assign busy     = running;
  assign accept   = start & ~busy;
  assign head_idx = free_head[IDX_W-1:0];
  assign cnt_last = (cnt == IDX_W'(POOL_ENTRIES - 1));

  assign create_ok = (free_head < LINK_W'(POOL_ENTRIES)) && (lifetime != '0);

  assign sx_ext = 32'(start_x);
  assign sy_ext = 32'(start_y);
  assign vx_ext = 32'(vel_x);
  assign vy_ext = 32'(vel_y);
  assign ld_px  = sx_ext[COORD_BITS-1:0];
  assign ld_py  = sy_ext[COORD_BITS-1:0];
  assign ld_vx  = vx_ext[COORD_BITS-1:0];
  assign ld_vy  = vy_ext[COORD_BITS-1:0];

  // update the entry at the chain head
  assign p_was_live = (c_life[0] != '0);
  assign p_life     = p_was_live ? (c_life[0] - LW'(1)) : '0;
  assign p_live     = (p_life != '0);
  assign p_rel      = p_was_live && !p_live;
  assign p_px       = p_was_live ? (c_px[0] + c_vx[0]) : c_px[0];
  assign p_py       = p_was_live ? (c_py[0] + c_vy[0]) : c_py[0];
  assign o_px       = 32'(p_px);
  assign o_py       = 32'(p_py);
  assign n_px       = 32'(ld_px);
  assign n_py       = 32'(ld_py);

  always_comb begin
    for (int i = 0; i < POOL_ENTRIES - 1; i++) begin
      s_life[i] = c_life[i+1];
      s_px[i]   = c_px[i+1];
      s_py[i]   = c_py[i+1];
      s_vx[i]   = c_vx[i+1];
      s_vy[i]   = c_vy[i+1];
      s_link[i] = c_link[i+1];
    end
    s_life[POOL_ENTRIES-1] = p_life;
    s_px[POOL_ENTRIES-1]   = p_px;
    s_py[POOL_ENTRIES-1]   = p_py;
    s_vx[POOL_ENTRIES-1]   = c_vx[0];
    s_vy[POOL_ENTRIES-1]   = c_vy[0];
    s_link[POOL_ENTRIES-1] = p_rel ? free_head : c_link[0];
  end

  for (genvar g = 0; g < POOL_ENTRIES; g++) begin : g_cell
    lpfl_pkg::cell_ctrl_t ctrl;

    assign ctrl.shift = running;
    assign ctrl.load  = accept && (kind == lpfl_pkg::KIND_CREATE) && create_ok &&
                        (head_idx == IDX_W'(g));

    lpfl_cell #(
      .COORD_BITS (COORD_BITS),
      .LINK_W     (LINK_W),
      .RESET_LINK (g + 1)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .sh_life (s_life[g]),
      .sh_px   (s_px[g]),
      .sh_py   (s_py[g]),
      .sh_vx   (s_vx[g]),
      .sh_vy   (s_vy[g]),
      .sh_link (s_link[g]),
      .ld_life (lifetime),
      .ld_px   (ld_px),
      .ld_py   (ld_py),
      .ld_vx   (ld_vx),
      .ld_vy   (ld_vy),
      .life    (c_life[g]),
      .px      (c_px[g]),
      .py      (c_py[g]),
      .vx      (c_vx[g]),
      .vy      (c_vy[g]),
      .link    (c_link[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      cnt       <= '0;
      free_head <= '0;
      strobe    <= 1'b0;
    end else begin
      strobe <= (accept && (kind == lpfl_pkg::KIND_CREATE)) || running;
      if (running) begin
        cnt <= cnt + IDX_W'(1);
        if (cnt_last) begin
          running <= 1'b0;
        end
        if (p_rel) begin
          free_head <= LINK_W'(cnt);
        end
      end else if (accept) begin
        if (kind == lpfl_pkg::KIND_TICK) begin
          running <= 1'b1;
          cnt     <= '0;
        end else if (create_ok) begin
          free_head <= c_link[head_idx];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (running) begin
      slot      <= lpfl_pkg::SLOT_W'(cnt);
      accepted  <= 1'b0;
      live      <= p_live;
      life_left <= p_life;
      pos_x     <= p_live ? o_px[lpfl_pkg::FIELD_W-1:0] : '0;
      pos_y     <= p_live ? o_py[lpfl_pkg::FIELD_W-1:0] : '0;
      released  <= p_rel;
      last      <= cnt_last;
    end else if (create_ok) begin
      slot      <= lpfl_pkg::SLOT_W'(head_idx);
      accepted  <= 1'b1;
      live      <= 1'b1;
      life_left <= lifetime;
      pos_x     <= n_px[lpfl_pkg::FIELD_W-1:0];
      pos_y     <= n_py[lpfl_pkg::FIELD_W-1:0];
      released  <= 1'b0;
      last      <= 1'b1;
    end else begin
      slot      <= '0;
      accepted  <= 1'b0;
      live      <= 1'b0;
      life_left <= '0;
      pos_x     <= '0;
      pos_y     <= '0;
      released  <= 1'b0;
      last      <= 1'b1;
    end
  end

endmodule

// ===== sim/pool_report_checker.sv =====
// ----------------------------------------------------------------------------
// pool_report_checker: slot report predictor and comparator
// Watches the item and result channels of the lifetime pool free list,
// keeps its own copy of the pool and free list, queues the slot reports
// each accepted beat should produce and compares every strobed result
// against the oldest one. Failure and coverage counts go to the top.
// ----------------------------------------------------------------------------
module pool_report_checker
  import lpfl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               kind,
  input  logic [LIFE_W-1:0]  lifetime,
  input  logic [FIELD_W-1:0] start_x,
  input  logic [FIELD_W-1:0] start_y,
  input  logic [FIELD_W-1:0] vel_x,
  input  logic [FIELD_W-1:0] vel_y,
  input  logic               strobe,
  input  logic [SLOT_W-1:0]  slot,
  input  logic               accepted,
  input  logic               live,
  input  logic [LIFE_W-1:0]  life_left,
  input  logic [FIELD_W-1:0] pos_x,
  input  logic [FIELD_W-1:0] pos_y,
  input  logic               released,
  input  logic               last,
  output int                 fail_count,
  output int                 pending,
  output int                 creates,
  output int                 refused,
  output int                 ticks,
  output int                 releases
);

  localparam int POOL = POOL_ENTRIES_DEF;
  localparam logic [3:0] NO_ENTRY = 4'(POOL);

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic               accepted;
    logic               live;
    logic [LIFE_W-1:0]  life_left;
    logic [FIELD_W-1:0] pos_x;
    logic [FIELD_W-1:0] pos_y;
    logic               released;
    logic               last;
  } slot_report_t;

  logic [LIFE_W-1:0]  entry_life [POOL];
  logic [FIELD_W-1:0] entry_px   [POOL];
  logic [FIELD_W-1:0] entry_py   [POOL];
  logic [FIELD_W-1:0] entry_vx   [POOL];
  logic [FIELD_W-1:0] entry_vy   [POOL];
  logic [3:0]         free_link  [POOL];
  logic [3:0]         free_head;

  slot_report_t reports_due [$];
  int mismatches = 0;
  int n_create = 0;
  int n_refused = 0;
  int n_tick = 0;
  int n_released = 0;

  function automatic string show(slot_report_t r);
    return $sformatf("slot %0d acc %b live %b life %0d x %h y %h rel %b last %b",
                     r.slot, r.accepted, r.live, r.life_left, r.pos_x, r.pos_y,
                     r.released, r.last);
  endfunction

  task automatic take_entry(input logic [LIFE_W-1:0] lt, input logic [FIELD_W-1:0] sx,
                            input logic [FIELD_W-1:0] sy, input logic [FIELD_W-1:0] vx,
                            input logic [FIELD_W-1:0] vy);
    slot_report_t r;
    logic [3:0] h;
    h = free_head;
    r = '0;
    r.last = 1'b1;
    n_create++;
    if (h >= NO_ENTRY || lt == '0) begin
      n_refused++;
    end else begin
      free_head = free_link[h];
      entry_life[h] = lt;
      entry_px[h] = sx;
      entry_py[h] = sy;
      entry_vx[h] = vx;
      entry_vy[h] = vy;
      r.slot = h[SLOT_W-1:0];
      r.accepted = 1'b1;
      r.live = 1'b1;
      r.life_left = lt;
      r.pos_x = sx;
      r.pos_y = sy;
    end
    reports_due.push_back(r);
  endtask

  task automatic age_pool();
    slot_report_t r;
    n_tick++;
    for (int i = 0; i < POOL; i++) begin
      r = '0;
      r.slot = i[SLOT_W-1:0];
      r.last = (i == POOL - 1);
      if (entry_life[i] != '0) begin
        entry_life[i] = entry_life[i] - 1'b1;
        entry_px[i] = entry_px[i] + entry_vx[i];
        entry_py[i] = entry_py[i] + entry_vy[i];
        if (entry_life[i] == '0) begin
          free_link[i] = free_head;
          free_head = i[3:0];
          r.released = 1'b1;
          n_released++;
        end
      end
      if (entry_life[i] != '0) begin
        r.live = 1'b1;
        r.life_left = entry_life[i];
        r.pos_x = entry_px[i];
        r.pos_y = entry_py[i];
      end
      reports_due.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    slot_report_t got;
    slot_report_t want;
    if (rst) begin
      for (int i = 0; i < POOL; i++) begin
        entry_life[i] = '0;
        entry_px[i] = '0;
        entry_py[i] = '0;
        entry_vx[i] = '0;
        entry_vy[i] = '0;
        free_link[i] = 4'(i + 1);
      end
      free_head = '0;
      reports_due.delete();
    end else begin
      if (strobe) begin
        got = '{slot, accepted, live, life_left, pos_x, pos_y, released, last};
        if (reports_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with no beat waiting: %s", $realtime, show(got));
          mismatches++;
        end else begin
          want = reports_due.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("%0t: slot report mismatch", $realtime);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        if (kind == KIND_CREATE)
          take_entry(lifetime, start_x, start_y, vel_x, vel_y);
        else
          age_pool();
      end
    end
    fail_count <= mismatches;
    pending <= reports_due.size();
    creates <= n_create;
    refused <= n_refused;
    ticks <= n_tick;
    releases <= n_released;
  end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: top level for the lifetime pool free list
// Drives create and tick beats in random bursts: a directed opening that
// fills the pool, overflows it, refuses a zero lifetime and expires
// entries, then mostly short-lived random traffic. The checker predicts
// and compares every slot report; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import lpfl_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               kind = KIND_CREATE;
  logic [LIFE_W-1:0]  lifetime = '0;
  logic [FIELD_W-1:0] start_x = '0;
  logic [FIELD_W-1:0] start_y = '0;
  logic [FIELD_W-1:0] vel_x = '0;
  logic [FIELD_W-1:0] vel_y = '0;

  logic               busy;
  logic               strobe;
  logic [SLOT_W-1:0]  slot;
  logic               accepted;
  logic               live;
  logic [LIFE_W-1:0]  life_left;
  logic [FIELD_W-1:0] pos_x;
  logic [FIELD_W-1:0] pos_y;
  logic               released;
  logic               last;

  int fail_count;
  int pending;
  int creates;
  int refused;
  int ticks;
  int releases;
  int burst_left = 0;

  always #5 clk = ~clk;

  lifetime_pool_free_list dut (.*);

  pool_report_checker checker_i (.*);

  task automatic send_beat(input logic k, input logic [LIFE_W-1:0] lt,
                           input logic [FIELD_W-1:0] sx, input logic [FIELD_W-1:0] sy,
                           input logic [FIELD_W-1:0] vx, input logic [FIELD_W-1:0] vy);
    start <= 1'b1;
    kind <= k;
    lifetime <= lt;
    start_x <= sx;
    start_y <= sy;
    vel_x <= vx;
    vel_y <= vy;
    do @(posedge clk); while (busy);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  endtask

  task automatic spawn(input logic [LIFE_W-1:0] lt);
    send_beat(KIND_CREATE, lt, FIELD_W'($urandom), FIELD_W'($urandom),
              FIELD_W'($urandom), FIELD_W'($urandom));
  endtask

  task automatic drain_pool_reports();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [LIFE_W-1:0] pick_life();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return LIFE_W'($urandom_range(1, 255));
      default: return LIFE_W'($urandom_range(1, 6));
    endcase
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // zero lifetime, then extremes of position and velocity
    spawn('0);
    send_beat(KIND_CREATE, 8'd255, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_beat(KIND_CREATE, 8'd1, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001);
    send_beat(KIND_CREATE, 8'd2, '0, '0, '0, '0);
    for (int k = 0; k < 5; k++) spawn(8'd3);
    // pool full
    spawn(8'd9);
    // ticks ignore the create fields
    send_beat(KIND_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_beat(KIND_TICK, '0, '0, '0, '0, '0);
    send_beat(KIND_TICK, 8'hA5, 16'h5A5A, 16'hA5A5, 16'h1234, 16'hEDCB);
    // several freed in one tick: highest index comes back first
    for (int k = 0; k < 3; k++) spawn(LIFE_W'(k + 1));
    send_beat(KIND_TICK, '0, '0, '0, '0, '0);

    drain_pool_reports();

    for (int n = 0; n < 160; n++) begin
      if (n == 80) drain_pool_reports();
      if ($urandom_range(0, 9) < 6)
        spawn(pick_life());
      else
        send_beat(KIND_TICK, LIFE_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
                  FIELD_W'($urandom), FIELD_W'($urandom));
    end

    drain_pool_reports();
    repeat (20) @(posedge clk);
    $display("covered %0d creates (%0d refused) and %0d ticks, %0d entries expired",
             creates, refused, ticks, releases);
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
